FILE: rtl/core/tab_pkg.sv
// ----------------------------------------------------------------------------
// tab_pkg
// Shared types, widths and helpers for the tinted alpha blend pixel block.
// ----------------------------------------------------------------------------
package tab_pkg;

    localparam int CH_W    = 8;                // one color or alpha channel
    localparam int PROD_W  = 2 * CH_W;         // 8x8 product
    localparam int NUM_W   = 3 * CH_W;         // blend numerator, <= 255 * 65025
    localparam int DEN_W   = 2 * CH_W;         // blend denominator, <= 65025
    localparam int NUM_CH  = 3;                // red, green, blue lanes
    localparam int CFG_IDX_W = 3;

    localparam logic [CH_W-1:0] CH_MAX = {CH_W{1'b1}};

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TINT_RED   = 3'd0,
        REG_TINT_GREEN = 3'd1,
        REG_TINT_BLUE  = 3'd2,
        REG_TINT_ALPHA = 3'd3
    } cfg_reg_t;

    // One stage of the shared-denominator restoring divider
    typedef struct packed {
        logic [NUM_CH-1:0][NUM_W-1:0] rem;
        logic [NUM_CH-1:0][CH_W-1:0]  quo;
        logic [DEN_W-1:0]             den;
        logic [CH_W-1:0]              alpha;
    } div_stage_t;

    // floor(x / 255), exact for every 8x8 product
    function automatic logic [CH_W-1:0] div255(input logic [PROD_W-1:0] x);
        logic [PROD_W:0] t;
        t = {1'b0, x} + {{(CH_W+1){1'b0}}, x[PROD_W-1:CH_W]} + (PROD_W+1)'(1);
        return t[PROD_W-1:CH_W];
    endfunction

endpackage

FILE: rtl/core/tinted_alpha_blend_pixel.sv
// ----------------------------------------------------------------------------
// tinted_alpha_blend_pixel
// Tinted source-over compositing of one RGBA8 pixel pair per beat.
// ----------------------------------------------------------------------------
// Throughput: one pixel per cycle while m_ready holds; 12 register stages,
// 8 of them the one-bit-per-stage divider that resolves the blend quotient.
// Stages advance independently, so bubbles collapse under output back-pressure.
// Reset (aresetn low, synchronous): pipeline emptied, tint registers set to 255.
// ----------------------------------------------------------------------------
module tinted_alpha_blend_pixel
    import tab_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,

    // Configuration write port
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_wr_index,
    input  logic [CH_W-1:0]      cfg_wr_data,

    // Input pixel pair
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [CH_W-1:0]      s_src_red,
    input  logic [CH_W-1:0]      s_src_green,
    input  logic [CH_W-1:0]      s_src_blue,
    input  logic [CH_W-1:0]      s_src_alpha,
    input  logic [CH_W-1:0]      s_dst_red,
    input  logic [CH_W-1:0]      s_dst_green,
    input  logic [CH_W-1:0]      s_dst_blue,
    input  logic [CH_W-1:0]      s_dst_alpha,

    // Blended result
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [CH_W-1:0]      m_out_red,
    output logic [CH_W-1:0]      m_out_green,
    output logic [CH_W-1:0]      m_out_blue,
    output logic [CH_W-1:0]      m_out_alpha
);

    localparam int QW = CH_W;   // quotient bits, one divider stage each

    // ------------------------------------------------------------------
    // Tint registers
    // ------------------------------------------------------------------
    logic [CH_W-1:0] tint_red_reg, tint_green_reg, tint_blue_reg, tint_alpha_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tint_red_reg   <= CH_MAX;
            tint_green_reg <= CH_MAX;
            tint_blue_reg  <= CH_MAX;
            tint_alpha_reg <= CH_MAX;
        end else if (cfg_wr_en) begin
            unique case (cfg_reg_t'(cfg_wr_index))
                REG_TINT_RED:   tint_red_reg   <= cfg_wr_data;
                REG_TINT_GREEN: tint_green_reg <= cfg_wr_data;
                REG_TINT_BLUE:  tint_blue_reg  <= cfg_wr_data;
                REG_TINT_ALPHA: tint_alpha_reg <= cfg_wr_data;
                default: ;   // drop writes past the register list
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Per-stage advance: a stage loads when it is empty or its successor
    // loads. The last divider stage is the output register.
    // ------------------------------------------------------------------
    logic          v1_reg, v2_reg, v3_reg, v4_reg;
    logic          ce1, ce2, ce3, ce4;
    logic [QW-1:0] div_v_reg;
    logic [QW-1:0] div_ce;

    assign ce4     = !v4_reg || div_ce[0];
    assign ce3     = !v3_reg || ce4;
    assign ce2     = !v2_reg || ce3;
    assign ce1     = !v1_reg || ce2;
    assign s_ready = ce1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else begin
            if (ce1) v1_reg <= s_valid;
            if (ce2) v2_reg <= v1_reg;
            if (ce3) v3_reg <= v2_reg;
            if (ce4) v4_reg <= v3_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: raw tint products s * t
    // ------------------------------------------------------------------
    logic [NUM_CH-1:0][PROD_W-1:0] s1_col_prod_reg;
    logic [PROD_W-1:0]             s1_alpha_prod_reg;
    logic [NUM_CH-1:0][CH_W-1:0]   s1_dst_reg;
    logic [CH_W-1:0]               s1_dst_alpha_reg;

    always_ff @(posedge aclk) begin
        if (ce1) begin
            s1_col_prod_reg[0] <= PROD_W'(s_src_red)   * PROD_W'(tint_red_reg);
            s1_col_prod_reg[1] <= PROD_W'(s_src_green) * PROD_W'(tint_green_reg);
            s1_col_prod_reg[2] <= PROD_W'(s_src_blue)  * PROD_W'(tint_blue_reg);
            s1_alpha_prod_reg  <= PROD_W'(s_src_alpha) * PROD_W'(tint_alpha_reg);
            s1_dst_reg[0]      <= s_dst_red;
            s1_dst_reg[1]      <= s_dst_green;
            s1_dst_reg[2]      <= s_dst_blue;
            s1_dst_alpha_reg   <= s_dst_alpha;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: scale products back to 8 bits, floor(p / 255)
    // ------------------------------------------------------------------
    logic [NUM_CH-1:0][CH_W-1:0] s2_src_reg;
    logic [CH_W-1:0]             s2_a_reg;
    logic [NUM_CH-1:0][CH_W-1:0] s2_dst_reg;
    logic [CH_W-1:0]             s2_da_reg;

    always_ff @(posedge aclk) begin
        if (ce2) begin
            for (int c = 0; c < NUM_CH; c++) begin
                s2_src_reg[c] <= div255(s1_col_prod_reg[c]);
            end
            s2_a_reg   <= div255(s1_alpha_prod_reg);
            s2_dst_reg <= s1_dst_reg;
            s2_da_reg  <= s1_dst_alpha_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: blend weights and first-level products, output alpha
    // ------------------------------------------------------------------
    logic [CH_W-1:0]   s2_inv;
    logic [CH_W:0]     s2_alpha_sum;
    logic [CH_W-1:0]   s3_alpha_next;

    assign s2_inv        = CH_MAX - s2_a_reg;
    assign s2_alpha_sum  = {1'b0, s2_da_reg} + {1'b0, s2_a_reg};
    // saturate the alpha sum at full coverage
    assign s3_alpha_next = s2_alpha_sum[CH_W] ? CH_MAX : s2_alpha_sum[CH_W-1:0];

    logic [NUM_CH-1:0][PROD_W-1:0] s3_sa_reg;     // s * a
    logic [NUM_CH-1:0][PROD_W-1:0] s3_dd_reg;     // d * da
    logic [NUM_CH-1:0][CH_W-1:0]   s3_dst_reg;
    logic [PROD_W-1:0]             s3_a255_reg;   // a * 255
    logic [PROD_W-1:0]             s3_dainv_reg;  // da * (255 - a)
    logic [CH_W-1:0]               s3_inv_reg;
    logic                          s3_a_zero_reg;
    logic [CH_W-1:0]               s3_alpha_reg;

    always_ff @(posedge aclk) begin
        if (ce3) begin
            for (int c = 0; c < NUM_CH; c++) begin
                s3_sa_reg[c] <= PROD_W'(s2_src_reg[c]) * PROD_W'(s2_a_reg);
                s3_dd_reg[c] <= PROD_W'(s2_dst_reg[c]) * PROD_W'(s2_da_reg);
            end
            s3_dst_reg    <= s2_dst_reg;
            s3_a255_reg   <= {s2_a_reg, {CH_W{1'b0}}} - PROD_W'(s2_a_reg);
            s3_dainv_reg  <= PROD_W'(s2_da_reg) * PROD_W'(s2_inv);
            s3_inv_reg    <= s2_inv;
            s3_a_zero_reg <= (s2_a_reg == '0);
            s3_alpha_reg  <= s3_alpha_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: numerators and shared denominator.
    // A fully transparent source divides the destination by one so it
    // passes through the divider unchanged (the blend would divide by zero
    // when the destination alpha is zero as well).
    // ------------------------------------------------------------------
    div_stage_t div_in_next;
    div_stage_t div_in_reg;

    always_comb begin
        for (int c = 0; c < NUM_CH; c++) begin
            div_in_next.rem[c] = NUM_W'({s3_sa_reg[c], {CH_W{1'b0}}})
                               - NUM_W'(s3_sa_reg[c])
                               + NUM_W'(s3_dd_reg[c]) * NUM_W'(s3_inv_reg);
            div_in_next.quo[c] = '0;
        end
        div_in_next.den   = s3_a255_reg + s3_dainv_reg;
        div_in_next.alpha = s3_alpha_reg;
        if (s3_a_zero_reg) begin
            for (int c = 0; c < NUM_CH; c++) begin
                div_in_next.rem[c] = NUM_W'(s3_dst_reg[c]);
            end
            div_in_next.den = DEN_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (ce4) div_in_reg <= div_in_next;
    end

    // ------------------------------------------------------------------
    // Stages 5..12: restoring divider, one quotient bit per stage, MSB
    // first. The quotient is a weighted mean of two 8-bit values, so the
    // numerator is always below 256 * den and 8 bits suffice.
    // ------------------------------------------------------------------
    div_stage_t div_reg [QW];

    for (genvar k = 0; k < QW; k++) begin : g_div
        div_stage_t       stage_in;
        div_stage_t       stage_next;
        logic             stage_v_in;
        logic [NUM_W-1:0] den_shift;

        if (k == 0) begin : g_first
            assign stage_in   = div_in_reg;
            assign stage_v_in = v4_reg;
        end else begin : g_rest
            assign stage_in   = div_reg[k-1];
            assign stage_v_in = div_v_reg[k-1];
        end

        if (k == QW - 1) begin : g_last
            assign div_ce[k] = !div_v_reg[k] || m_ready;
        end else begin : g_mid
            assign div_ce[k] = !div_v_reg[k] || div_ce[k+1];
        end

        assign den_shift = NUM_W'(stage_in.den) << (QW - 1 - k);

        always_comb begin
            stage_next = stage_in;
            for (int c = 0; c < NUM_CH; c++) begin
                if (stage_in.rem[c] >= den_shift) begin
                    stage_next.rem[c] = stage_in.rem[c] - den_shift;
                    stage_next.quo[c] = {stage_in.quo[c][QW-2:0], 1'b1};
                end else begin
                    stage_next.quo[c] = {stage_in.quo[c][QW-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                div_v_reg[k] <= 1'b0;
            end else if (div_ce[k]) begin
                div_v_reg[k] <= stage_v_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (div_ce[k]) div_reg[k] <= stage_next;
        end
    end

    // ------------------------------------------------------------------
    // Output beat straight from the last divider stage
    // ------------------------------------------------------------------
    assign m_valid     = div_v_reg[QW-1];
    assign m_out_red   = div_reg[QW-1].quo[0];
    assign m_out_green = div_reg[QW-1].quo[1];
    assign m_out_blue  = div_reg[QW-1].quo[2];
    assign m_out_alpha = div_reg[QW-1].alpha;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // A taking sink must never back-pressure the input.
    a_ready_follows_sink: assert property (@(posedge aclk) disable iff (!aresetn)
        m_ready |-> s_ready)
        else $error("input stalled while output sink is ready");

    // The divider never sees a zero denominator.
    a_den_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        v4_reg |-> (div_in_reg.den != '0))
        else $error("zero blend denominator entered divider");

    // The transparent bypass must divide by one.
    a_bypass_den: assert property (@(posedge aclk) disable iff (!aresetn)
        (v3_reg && ce4 && s3_a_zero_reg) |=> (div_in_reg.den == DEN_W'(1)))
        else $error("transparent pixel not routed through unit divide");

    // Final remainders are below the denominator, so every quotient is exact.
    a_rem_below_den: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ((div_reg[QW-1].rem[0] < NUM_W'(div_reg[QW-1].den))
                  && (div_reg[QW-1].rem[1] < NUM_W'(div_reg[QW-1].den))
                  && (div_reg[QW-1].rem[2] < NUM_W'(div_reg[QW-1].den))))
        else $error("blend quotient overflowed 8 bits");

endmodule

FILE: sim/tinted_alpha_blend_pixel_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tinted_alpha_blend_pixel_tb
// Self-checking bench for the tinted source-over blend. Each pixel pair taken
// on s_* is run through a local integer model of the tint and the blend, and
// its prediction is queued. Every beat on m_* is checked field by field
// against the oldest prediction. Directed cases cover the opaque, clear and
// partial-alpha paths, the tint registers and ignored register indexes.
// Random phases then change the tint setting between traffic runs, with
// random gaps and stalls on both channels in all but the last two phases.
// ----------------------------------------------------------------------------
module tinted_alpha_blend_pixel_tb;
    import tab_pkg::*;

    typedef int unsigned uint_t;

    localparam int    PIPE_LATENCY  = 12;          // input beat to result beat
    localparam int    NUM_TINTS     = 4;
    localparam int    NUM_CFG_SLOTS = 1 << CFG_IDX_W;
    localparam int    TIMEOUT_NS    = 5_000_000;
    localparam int    RAND_PHASES   = 8;
    localparam int    PHASE_BEATS   = 100;
    localparam int    QUIET_PHASES  = 2;           // last phases run with no idling
    localparam uint_t CH_TOP        = uint_t'(CH_MAX);

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
        logic [CH_W-1:0] alpha;
    } rgba_t;

    typedef enum logic [1:0] {
        BLEND_CLEAR,
        BLEND_PARTIAL,
        BLEND_OPAQUE
    } blend_case_t;

    // ------------------------------------------------------------------------
    // DUT connections
    // ------------------------------------------------------------------------
    logic                 aclk;
    logic                 aresetn;
    logic                 cfg_wr_en;
    logic [CFG_IDX_W-1:0] cfg_wr_index;
    logic [CH_W-1:0]      cfg_wr_data;
    logic                 s_valid;
    logic                 s_ready;
    rgba_t                src_pix;
    rgba_t                dst_pix;
    logic                 m_valid;
    logic                 m_ready;
    rgba_t                out_pix;

    tinted_alpha_blend_pixel u_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_src_red    (src_pix.red),
        .s_src_green  (src_pix.green),
        .s_src_blue   (src_pix.blue),
        .s_src_alpha  (src_pix.alpha),
        .s_dst_red    (dst_pix.red),
        .s_dst_green  (dst_pix.green),
        .s_dst_blue   (dst_pix.blue),
        .s_dst_alpha  (dst_pix.alpha),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_out_red    (out_pix.red),
        .m_out_green  (out_pix.green),
        .m_out_blue   (out_pix.blue),
        .m_out_alpha  (out_pix.alpha)
    );

    // ------------------------------------------------------------------------
    // Bench state
    // ------------------------------------------------------------------------
    logic [CH_W-1:0] tint_model [NUM_TINTS];    // local copy of the tint registers
    rgba_t           pending_pixels [$];        // predicted blends, oldest first
    bit              source_gaps_on;
    bit              sink_stalls_on;
    int              mismatch_count;
    int              beats_sent;
    int              beats_checked;
    int              opaque_beats;
    int              clear_beats;
    int              partial_beats;
    int              tint_settings;

    // ------------------------------------------------------------------------
    // Clock and timeout
    // ------------------------------------------------------------------------
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Kill a hung run; nothing legal takes this long.
    initial begin
        #(TIMEOUT_NS);
        $display("tinted_alpha_blend_pixel_tb NOT OK");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------------

    // Weighted mean of source and destination lane, truncated.
    function automatic logic [CH_W-1:0] blend_lane(input uint_t s, input uint_t d,
                                                   input uint_t a, input uint_t da);
        uint_t inv;
        uint_t num;
        uint_t den;
        inv = CH_TOP - a;
        num = s * a * CH_TOP + d * da * inv;
        den = a * CH_TOP + da * inv;
        return CH_W'(num / den);
    endfunction

    // Tint the source with the current registers, then composite it over dst.
    function automatic rgba_t composite_pixel(input rgba_t src, input rgba_t dst,
                                              output blend_case_t kind);
        uint_t r;
        uint_t g;
        uint_t b;
        uint_t a;
        uint_t sum;
        rgba_t res;
        r = (uint_t'(src.red)   * uint_t'(tint_model[REG_TINT_RED]))   / CH_TOP;
        g = (uint_t'(src.green) * uint_t'(tint_model[REG_TINT_GREEN])) / CH_TOP;
        b = (uint_t'(src.blue)  * uint_t'(tint_model[REG_TINT_BLUE]))  / CH_TOP;
        a = (uint_t'(src.alpha) * uint_t'(tint_model[REG_TINT_ALPHA])) / CH_TOP;
        if (a == CH_TOP) begin
            kind = BLEND_OPAQUE;
            res  = '{CH_W'(r), CH_W'(g), CH_W'(b), CH_MAX};
        end else if (a == 0) begin
            kind = BLEND_CLEAR;
            res  = dst;
        end else begin
            kind      = BLEND_PARTIAL;
            res.red   = blend_lane(r, uint_t'(dst.red),   a, uint_t'(dst.alpha));
            res.green = blend_lane(g, uint_t'(dst.green), a, uint_t'(dst.alpha));
            res.blue  = blend_lane(b, uint_t'(dst.blue),  a, uint_t'(dst.alpha));
            sum       = uint_t'(dst.alpha) + a;
            res.alpha = (sum > CH_TOP) ? CH_MAX : CH_W'(sum);
        end
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // Shared tasks
    // ------------------------------------------------------------------------
    task automatic report_mismatch(input string msg);
        mismatch_count++;
        $display("[%0t] MISMATCH: %s", $realtime, msg);
    endtask

    // Drive one pixel pair and queue its prediction once the beat is taken.
    task automatic send_pixel_pair(input rgba_t src, input rgba_t dst);
        rgba_t       want;
        blend_case_t kind;
        @(negedge aclk);
        if (source_gaps_on && $urandom_range(0, 3) == 0) begin
            // Drop valid for a burst, then come back on a falling edge.
            s_valid = 1'b0;
            repeat ($urandom_range(1, 18)) @(negedge aclk);
        end
        src_pix = src;
        dst_pix = dst;
        s_valid = 1'b1;
        // Hold the beat until the block takes it.
        do @(posedge aclk); while (!s_ready);
        want = composite_pixel(src, dst, kind);
        pending_pixels.push_back(want);
        beats_sent++;
        case (kind)
            BLEND_OPAQUE: opaque_beats++;
            BLEND_CLEAR:  clear_beats++;
            default:      partial_beats++;
        endcase
    endtask

    // Lower valid, wait for every predicted beat, then let the pipe settle.
    task automatic wait_pipeline_empty();
        @(negedge aclk);
        s_valid = 1'b0;
        while (pending_pixels.size() != 0) @(negedge aclk);
        repeat (PIPE_LATENCY + 2) @(negedge aclk);
    endtask

    // One register write; indexes past the tint registers must be ignored.
    task automatic write_tint_reg(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CH_W-1:0] value);
        @(negedge aclk);
        cfg_wr_en    = 1'b1;
        cfg_wr_index = idx;
        cfg_wr_data  = value;
        @(negedge aclk);
        cfg_wr_en    = 1'b0;
        if (idx <= REG_TINT_ALPHA)
            tint_model[idx] = value;
    endtask

    task automatic write_all_tints(input logic [CH_W-1:0] red, input logic [CH_W-1:0] green,
                                   input logic [CH_W-1:0] blue, input logic [CH_W-1:0] alpha);
        write_tint_reg(REG_TINT_RED,   red);
        write_tint_reg(REG_TINT_GREEN, green);
        write_tint_reg(REG_TINT_BLUE,  blue);
        write_tint_reg(REG_TINT_ALPHA, alpha);
        tint_settings++;
    endtask

    // Channel value with extra weight on both ends of the range.
    function automatic logic [CH_W-1:0] rand_channel();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return CH_MAX;
            default: return CH_W'($urandom_range(0, CH_MAX));
        endcase
    endfunction

    // Alpha leans on the values that pick or border the three blend cases.
    function automatic logic [CH_W-1:0] rand_alpha();
        case ($urandom_range(0, 9))
            0:       return '0;
            1, 2:    return CH_MAX;
            3:       return CH_W'(1);
            4:       return CH_MAX - CH_W'(1);
            default: return CH_W'($urandom_range(0, CH_MAX));
        endcase
    endfunction

    function automatic rgba_t rand_rgba();
        return '{rand_channel(), rand_channel(), rand_channel(), rand_alpha()};
    endfunction

    // ------------------------------------------------------------------------
    // Result checking: compare every m_* beat with the oldest prediction
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        rgba_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_pixels.size() == 0) begin
                report_mismatch($sformatf("result beat with nothing expected (%h)", out_pix));
            end else begin
                want = pending_pixels.pop_front();
                beats_checked++;
                if (out_pix.red !== want.red)
                    report_mismatch($sformatf("beat %0d red got %0d want %0d",
                                              beats_checked, out_pix.red, want.red));
                if (out_pix.green !== want.green)
                    report_mismatch($sformatf("beat %0d green got %0d want %0d",
                                              beats_checked, out_pix.green, want.green));
                if (out_pix.blue !== want.blue)
                    report_mismatch($sformatf("beat %0d blue got %0d want %0d",
                                              beats_checked, out_pix.blue, want.blue));
                if (out_pix.alpha !== want.alpha)
                    report_mismatch($sformatf("beat %0d alpha got %0d want %0d",
                                              beats_checked, out_pix.alpha, want.alpha));
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result side back-pressure: random stall bursts while enabled
    // ------------------------------------------------------------------------
    initial begin
        m_ready = 1'b1;
        forever begin
            @(negedge aclk);
            if (sink_stalls_on && $urandom_range(0, 4) == 0) begin
                m_ready = 1'b0;
                repeat ($urandom_range(1, 18)) @(negedge aclk);
                m_ready = 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Opaque source: output is the tinted source color with full alpha.
    task automatic test_opaque_source();
        send_pixel_pair('{CH_MAX, 8'd0, 8'd128, CH_MAX}, '{8'd17, 8'd99, 8'd240, 8'd60});
        send_pixel_pair('{8'd0, CH_MAX, 8'd0, CH_MAX}, '{8'd0, 8'd0, 8'd0, 8'd0});
        send_pixel_pair('{CH_MAX, CH_MAX, CH_MAX, CH_MAX}, '{CH_MAX, CH_MAX, CH_MAX, CH_MAX});
    endtask

    // Clear source: destination passes through, alpha included.
    task automatic test_clear_source();
        send_pixel_pair('{CH_MAX, CH_MAX, CH_MAX, 8'd0}, '{8'd12, 8'd200, CH_MAX, 8'd0});
        send_pixel_pair('{8'd0, 8'd0, 8'd0, 8'd0}, '{CH_MAX, CH_MAX, CH_MAX, CH_MAX});
        send_pixel_pair('{8'd90, 8'd3, 8'd250, 8'd0}, '{8'd0, 8'd0, 8'd0, 8'd77});
    endtask

    // Partial alpha: blend, alpha at both ends and saturating alpha sum.
    task automatic test_partial_alpha();
        send_pixel_pair('{CH_MAX, 8'd0, 8'd128, 8'd1}, '{8'd0, CH_MAX, 8'd64, 8'd0});
        send_pixel_pair('{8'd0, CH_MAX, 8'd33, 8'd254}, '{CH_MAX, 8'd0, 8'd201, CH_MAX});
        send_pixel_pair('{8'd200, 8'd100, 8'd50, 8'd128}, '{8'd10, 8'd20, 8'd30, 8'd128});
        send_pixel_pair('{8'd77, 8'd150, CH_MAX, 8'd100}, '{8'd180, 8'd5, 8'd0, 8'd100});
        send_pixel_pair('{CH_MAX, CH_MAX, CH_MAX, 8'd1}, '{8'd0, 8'd0, 8'd0, CH_MAX});
        send_pixel_pair('{8'd0, 8'd0, 8'd0, 8'd254}, '{CH_MAX, CH_MAX, CH_MAX, 8'd0});
    endtask

    // Tint registers, including writes to indexes that must change nothing.
    task automatic test_tint_registers();
        for (int i = int'(REG_TINT_ALPHA) + 1; i < NUM_CFG_SLOTS; i++)
            write_tint_reg(CFG_IDX_W'(i), '0);
        send_pixel_pair('{CH_MAX, 8'd128, 8'd1, CH_MAX}, '{8'd9, 8'd9, 8'd9, 8'd9});
        wait_pipeline_empty();

        write_all_tints('0, 8'd128, 8'd1, CH_MAX);
        send_pixel_pair('{CH_MAX, CH_MAX, CH_MAX, CH_MAX}, '{8'd40, 8'd50, 8'd60, 8'd70});
        wait_pipeline_empty();

        // Zero alpha tint turns an opaque source into a clear one.
        write_tint_reg(REG_TINT_ALPHA, '0);
        send_pixel_pair('{CH_MAX, CH_MAX, CH_MAX, CH_MAX}, '{8'd40, 8'd50, 8'd60, 8'd70});
        wait_pipeline_empty();

        write_tint_reg(REG_TINT_ALPHA, CH_MAX - CH_W'(1));
        send_pixel_pair('{CH_MAX, CH_MAX, CH_MAX, CH_MAX}, '{8'd1, 8'd2, 8'd3, 8'd200});
        wait_pipeline_empty();

        write_tint_reg(REG_TINT_ALPHA, 8'd1);
        send_pixel_pair('{CH_MAX, CH_MAX, CH_MAX, CH_MAX}, '{CH_MAX, 8'd0, 8'd128, 8'd20});
        wait_pipeline_empty();

        write_all_tints(CH_MAX, CH_MAX, CH_MAX, 8'd128);
        send_pixel_pair('{8'd170, 8'd85, 8'd255, 8'd200}, '{8'd30, 8'd220, 8'd0, 8'd90});
        wait_pipeline_empty();
    endtask

    // Random traffic over a series of tint settings, idling off at the end.
    task automatic test_random_traffic();
        for (int phase = 0; phase < RAND_PHASES; phase++) begin
            wait_pipeline_empty();
            case (phase % 4)
                0: write_all_tints(CH_MAX, CH_MAX, CH_MAX, CH_MAX);
                1: write_all_tints($urandom_range(0, 1) ? CH_MAX : '0,
                                   $urandom_range(0, 1) ? CH_MAX : '0,
                                   $urandom_range(0, 1) ? CH_MAX : '0,
                                   $urandom_range(0, 1) ? CH_MAX : CH_W'(1));
                default: write_all_tints(rand_channel(), rand_channel(),
                                         rand_channel(), rand_alpha());
            endcase
            // Stray write to an unused index; the tints must hold.
            write_tint_reg(CFG_IDX_W'($urandom_range(int'(REG_TINT_ALPHA) + 1,
                                                     NUM_CFG_SLOTS - 1)),
                           CH_W'($urandom_range(0, CH_MAX)));
            source_gaps_on = (phase < RAND_PHASES - QUIET_PHASES);
            sink_stalls_on = (phase < RAND_PHASES - QUIET_PHASES);
            for (int n = 0; n < PHASE_BEATS; n++)
                send_pixel_pair(rand_rgba(), rand_rgba());
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        aresetn        = 1'b0;
        cfg_wr_en      = 1'b0;
        cfg_wr_index   = '0;
        cfg_wr_data    = '0;
        s_valid        = 1'b0;
        src_pix        = '0;
        dst_pix        = '0;
        source_gaps_on = 1'b1;
        sink_stalls_on = 1'b1;
        mismatch_count = 0;
        beats_sent     = 0;
        beats_checked  = 0;
        opaque_beats   = 0;
        clear_beats    = 0;
        partial_beats  = 0;
        tint_settings  = 1;
        for (int i = 0; i < NUM_TINTS; i++)
            tint_model[i] = CH_MAX;

        // Hold reset, then release it on a falling edge.
        repeat (4) @(negedge aclk);
        aresetn = 1'b1;

        test_opaque_source();
        test_clear_source();
        test_partial_alpha();
        wait_pipeline_empty();
        test_tint_registers();
        test_random_traffic();
        wait_pipeline_empty();

        $display("covered %0d pixel beats (%0d opaque, %0d clear, %0d partial), %0d checked",
                 beats_sent, opaque_beats, clear_beats, partial_beats, beats_checked);
        $display("over %0d tint settings, %0d mismatches", tint_settings, mismatch_count);
        if (mismatch_count == 0)
            $display("tinted_alpha_blend_pixel_tb OK");
        else
            $display("tinted_alpha_blend_pixel_tb NOT OK");
        $finish;
    end

endmodule
